// ===== design/rpc_pkg.sv =====
// rpc_pkg: shared constants and types for the rectangular/polar converter
// depends on nothing; used by rect_polar_converter_unit
`default_nettype none
package rpc_pkg;

  localparam int unsigned CORDIC_STEPS = 16;

  // input kind codes
  localparam logic [1:0] KIND_RECT  = 2'd0;
  localparam logic [1:0] KIND_POLAR = 2'd1;

  // q30 constants, angle words are 36 bits wide
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [30:0] K_Q30       = 31'sd652032874;

  // ceil(2^40 / 573), exact reciprocal for operands below 2^31
  localparam logic [30:0] RECIP_573 = 31'd1918868461;
  localparam int unsigned RECIP_SHIFT = 40;

  // atan(2^-i) in q30
  localparam logic signed [35:0] ATAN_Q30 [32] = '{
    36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159,
    36'sd67021687,  36'sd33543516,  36'sd16775851,  36'sd8388437,
    36'sd4194283,   36'sd2097149,   36'sd1048576,   36'sd524288,
    36'sd262144,    36'sd131072,    36'sd65536,     36'sd32768,
    36'sd16384,     36'sd8192,      36'sd4096,      36'sd2048,
    36'sd1024,      36'sd512,       36'sd256,       36'sd128,
    36'sd64,        36'sd32,        36'sd16,        36'sd8,
    36'sd4,         36'sd2,         36'sd1,         36'sd1
  };

  typedef struct packed {
    logic               rect;
    logic               bad;
    logic               zero;
    logic               flip;
    logic        [31:0] x_in;
    logic        [31:0] y_in;
    logic        [32:0] mag;
    logic        [19:0] a16;
    logic signed [63:0] cx;
    logic signed [63:0] cy;
    logic signed [35:0] cz;
  } pipe_t;

endpackage
`default_nettype wire

// ===== design/rect_polar_converter_unit.sv =====
// rect_polar_converter_unit: pipelined cordic converter between rectangular and polar form
// depends on rpc_pkg
`default_nettype none
// usage
//   a request is taken at each rising edge where start is high and busy is low;
//   busy stays low, so a new request can enter on every cycle
//   kind_i selects rectangular (x, y) or polar (magnitude, angle in degrees) input;
//   each request yields x, y, magnitude and angle in radians, or all zeros with
//   bad_kind_o set for an unknown kind
//   the result shows on the output ports for exactly one cycle with valid_o high
// timing
//   from the accepting edge a request passes through one input register, three
//   preparation stages (reciprocal multiply for the degree scaling, angle wrap,
//   half-plane fold), one stage per cordic iteration, and two output stages
//   (gain multiply, rounding and clamp)
//   throughput is one request per cycle, set by the fully unrolled cordic pipe
// reset
//   rst_ni clears all valid bits asynchronously; payload registers are not reset
// flow
//   the receiver cannot stall, so every stage advances on every clock
module rect_polar_converter_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic        [1:0]  kind_i,
  input  wire logic signed [31:0] first_value_i,
  input  wire logic signed [25:0] second_value_i,
  output      logic               valid_o,
  output      logic signed [31:0] x_out_o,
  output      logic signed [31:0] y_out_o,
  output      logic signed [32:0] magnitude_o,
  output      logic signed [19:0] angle_rad_o,
  output      logic               bad_kind_o
);

  localparam int unsigned N = rpc_pkg::CORDIC_STEPS;

  // pipe never blocks
  assign busy = 1'b0;

  // ---------------- stage 1: input register
  logic               v1_q;
  logic [1:0]         kind1_q;
  logic signed [31:0] fv1_q;
  logic signed [25:0] sv1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    kind1_q <= kind_i;
    fv1_q   <= first_value_i;
    sv1_q   <= second_value_i;
  end

  // ---------------- stage 2: rectangular setup, degree scaling and gain multiply
  rpc_pkg::pipe_t     p2_d, p2_q;
  logic               v2_q;
  logic signed [29:0] deg10;
  logic [28:0]        deg_abs;
  logic [28:0]        deg_rnd;
  logic [59:0]        prod_d, prod_q;
  logic               neg_d, neg_q;
  logic signed [62:0] mk_d, mk_q;
  logic signed [63:0] rx, ry;

  always_comb begin
    deg10   = 30'(sv1_q) * 30'sd10;
    neg_d   = deg10[29];
    deg_abs = neg_d ? 29'(-deg10) : deg10[28:0];
    // round half away from zero on the magnitude
    deg_rnd = deg_abs + 29'd286;
    prod_d  = 60'(deg_rnd) * 60'(rpc_pkg::RECIP_573);
    mk_d    = fv1_q * rpc_pkg::K_Q30;

    rx = 64'(fv1_q) <<< 14;
    ry = 64'(sv1_q) <<< 14;

    p2_d      = '0;
    p2_d.rect = (kind1_q == rpc_pkg::KIND_RECT);
    p2_d.bad  = (kind1_q != rpc_pkg::KIND_RECT) && (kind1_q != rpc_pkg::KIND_POLAR);
    p2_d.zero = (fv1_q == 32'sd0) && (sv1_q == 26'sd0);
    p2_d.x_in = fv1_q;
    p2_d.y_in = 32'(sv1_q);
    p2_d.mag  = 33'(fv1_q);
    // left half plane: turn by pi and start the angle at +-pi
    if (fv1_q[31]) begin
      p2_d.cx = -rx;
      p2_d.cy = -ry;
      p2_d.cz = sv1_q[25] ? -rpc_pkg::PI_Q30 : rpc_pkg::PI_Q30;
    end else begin
      p2_d.cx = rx;
      p2_d.cy = ry;
      p2_d.cz = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_q   <= p2_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
    mk_q   <= mk_d;
  end

  // ---------------- stage 3: radians and wrap into [-pi, pi]
  rpc_pkg::pipe_t     p3_d, p3_q;
  logic               v3_q;
  logic [19:0]        quo;
  logic signed [19:0] a16;
  logic signed [35:0] za;

  always_comb begin
    quo  = prod_q[rpc_pkg::RECIP_SHIFT +: 20];
    // clamp the radian value to the 20-bit output range
    priority if (!neg_q && (quo > 20'd524287)) begin
      a16 = 20'sh7ffff;
    end else if (neg_q && (quo > 20'd524288)) begin
      a16 = 20'sh80000;
    end else if (neg_q) begin
      a16 = 20'(-$signed({1'b0, quo}));
    end else begin
      a16 = $signed(quo);
    end
    za   = 36'(a16) <<< 14;
    p3_d = p2_q;
    p3_d.a16 = a16;
    if (!p2_q.rect) begin
      p3_d.cx = 64'(mk_q) >>> 16;
      p3_d.cy = '0;
      if (za > rpc_pkg::PI_Q30) begin
        p3_d.cz = za - rpc_pkg::TWO_PI_Q30;
      end else if (za < -rpc_pkg::PI_Q30) begin
        p3_d.cz = za + rpc_pkg::TWO_PI_Q30;
      end else begin
        p3_d.cz = za;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p3_q <= p3_d;
  end

  // ---------------- stage 4: fold into [-pi/2, pi/2], feeds the cordic pipe
  rpc_pkg::pipe_t st_q [N+1];
  rpc_pkg::pipe_t p4_d;
  logic           vst_q [N+1];

  always_comb begin
    p4_d = p3_q;
    if (!p3_q.rect) begin
      if (p3_q.cz > rpc_pkg::HALF_PI_Q30) begin
        p4_d.cz   = p3_q.cz - rpc_pkg::PI_Q30;
        p4_d.flip = 1'b1;
      end else if (p3_q.cz < -rpc_pkg::HALF_PI_Q30) begin
        p4_d.cz   = p3_q.cz + rpc_pkg::PI_Q30;
        p4_d.flip = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vst_q[0] <= 1'b0;
    end else begin
      vst_q[0] <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= p4_d;
  end

  // ---------------- cordic iterations, one per stage
  // vectoring for rectangular input (drive y to zero), rotation for polar input
  for (genvar i = 0; i < N; i++) begin : g_cordic
    rpc_pkg::pipe_t nx;
    logic           up;

    always_comb begin
      nx = st_q[i];
      up = st_q[i].rect ? st_q[i].cy[63] : ~st_q[i].cz[35];
      if (up) begin
        nx.cx = st_q[i].cx - (st_q[i].cy >>> i);
        nx.cy = st_q[i].cy + (st_q[i].cx >>> i);
        nx.cz = st_q[i].cz - rpc_pkg::ATAN_Q30[i];
      end else begin
        nx.cx = st_q[i].cx + (st_q[i].cy >>> i);
        nx.cy = st_q[i].cy - (st_q[i].cx >>> i);
        nx.cz = st_q[i].cz + rpc_pkg::ATAN_Q30[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vst_q[i+1] <= 1'b0;
      end else begin
        vst_q[i+1] <= vst_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[i+1] <= nx;
    end
  end

  // ---------------- output stage a: gain multiply, sign restore and rounding
  rpc_pkg::pipe_t     pa_q;
  logic               va_q;
  logic [53:0]        mh_d, mh_q, ml_d, ml_q;
  logic signed [63:0] fx, fy;
  logic signed [63:0] xr_d, xr_q, yr_d, yr_q;
  logic signed [35:0] zr;
  logic [19:0]        ar_d, ar_q;

  always_comb begin
    // magnitude times gain, split so each product stays narrow
    mh_d = 54'(st_q[N].cx[47:24]) * 54'(rpc_pkg::K_Q30);
    ml_d = 54'(st_q[N].cx[23:0])  * 54'(rpc_pkg::K_Q30);
    fx   = st_q[N].flip ? -st_q[N].cx : st_q[N].cx;
    fy   = st_q[N].flip ? -st_q[N].cy : st_q[N].cy;
    xr_d = (fx + 64'sd8192) >>> 14;
    yr_d = (fy + 64'sd8192) >>> 14;
    zr   = (st_q[N].cz + 36'sd8192) >>> 14;
    ar_d = zr[19:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= vst_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q <= st_q[N];
    mh_q <= mh_d;
    ml_q <= ml_d;
    xr_q <= xr_d;
    yr_q <= yr_d;
    ar_q <= ar_d;
  end

  // ---------------- output stage b: result select and clamp
  logic [54:0]        tot;
  logic signed [31:0] xo_d, yo_d;
  logic signed [32:0] mo_d;
  logic signed [19:0] ao_d;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    tot = 55'(mh_q) + 55'(ml_q >> 24) + 55'(1 << 19);
    priority if (pa_q.bad) begin
      xo_d = '0;
      yo_d = '0;
      mo_d = '0;
      ao_d = '0;
    end else if (pa_q.rect) begin
      xo_d = pa_q.x_in;
      yo_d = pa_q.y_in;
      // zero vector gives zero length and zero angle
      mo_d = pa_q.zero ? 33'sd0 : $signed(tot[52:20]);
      ao_d = pa_q.zero ? 20'sd0 : $signed(ar_q);
    end else begin
      xo_d = sat32(xr_q);
      yo_d = sat32(yr_q);
      mo_d = pa_q.mag;
      ao_d = pa_q.a16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_out_o     <= xo_d;
    y_out_o     <= yo_d;
    magnitude_o <= mo_d;
    angle_rad_o <= ao_d;
    bad_kind_o  <= pa_q.bad;
  end

endmodule
`default_nettype wire
